>>> hw/rtl/imh_pkg.sv
`timescale 1ns / 1ps

package imh_pkg;

  localparam int CAPACITY_DEF = 1024;
  localparam int KEY_BITS_DEF = 32;
  localparam int ID_SPACE     = 1024;
  localparam int ID_BITS      = 10;
  localparam int POS_BITS     = 10;
  localparam int KEY_IN_BITS  = 32;
  localparam int FPOS_BITS    = 11;

  localparam logic [FPOS_BITS-1:0] POS_ABSENT = 11'd1024;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BAD_POS = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    OP_APPEND = 3'd0,
    OP_BUILD  = 3'd1,
    OP_CHANGE = 3'd2,
    OP_REMOVE = 3'd3,
    OP_LOCATE = 3'd4,
    OP_NONE   = 3'd5
  } op_t;

  typedef struct packed {
    op_t                   op;
    logic [POS_BITS-1:0]   position;
    logic [ID_BITS-1:0]    entry_id;
    logic [KEY_IN_BITS-1:0] key;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } head_t;

endpackage

>>> hw/rtl/indexed_min_heap_engine.sv
`timescale 1ns / 1ps

// Indexed binary min-heap of (key, id) pairs with an id-to-position map. A two-entry input
// queue takes transactions while the heap sequencer works; results wait in an output register.
// After reset a clearing pass over all 1024 ids marks every id absent, and full stays high
// until it ends. Append, a bad position, a full heap and an unknown mode go from idle
// straight to the root read and the result state; locate reads the id map first. Change key
// and remove walk the heap one level per step, where each step is one read of
// the slot memory (two read ports, one write port) then a compare and write; build sifts
// down each of the count/2 inner nodes in turn, from the last inner node to the root.
module indexed_min_heap_engine #(
  parameter int CAPACITY = imh_pkg::CAPACITY_DEF,
  parameter int KEY_BITS = imh_pkg::KEY_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_push,
  output logic                            in_full,
  input  logic [2:0]                      in_mode,
  input  logic [imh_pkg::POS_BITS-1:0]    in_position,
  input  logic [imh_pkg::ID_BITS-1:0]     in_entry_id,
  input  logic [imh_pkg::KEY_IN_BITS-1:0] in_key,
  output logic                            out_empty,
  input  logic                            out_pop,
  output logic [1:0]                      out_status,
  output logic [imh_pkg::FPOS_BITS-1:0]   out_final_position,
  output logic [imh_pkg::KEY_IN_BITS-1:0] out_min_key,
  output logic [imh_pkg::ID_BITS-1:0]     out_min_id,
  output logic [imh_pkg::FPOS_BITS-1:0]   out_count,
  output logic                            out_empty_res
);
  import imh_pkg::*;

  head_t head;
  logic  head_pop;
  logic  clearing;

  imh_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_push     (in_push),
    .in_full     (in_full),
    .in_mode     (in_mode),
    .in_position (in_position),
    .in_entry_id (in_entry_id),
    .in_key      (in_key),
    .clearing    (clearing),
    .head        (head),
    .head_pop    (head_pop)
  );

  imh_back #(
    .CAPACITY (CAPACITY),
    .KEY_BITS (KEY_BITS)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .head               (head),
    .head_pop           (head_pop),
    .clearing           (clearing),
    .out_empty          (out_empty),
    .out_pop            (out_pop),
    .out_status         (out_status),
    .out_final_position (out_final_position),
    .out_min_key        (out_min_key),
    .out_min_id         (out_min_id),
    .out_count          (out_count),
    .out_empty_res      (out_empty_res)
  );

endmodule

>>> hw/rtl/imh_front.sv
`timescale 1ns / 1ps

module imh_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_push,
  output logic                          in_full,
  input  logic [2:0]                    in_mode,
  input  logic [imh_pkg::POS_BITS-1:0]  in_position,
  input  logic [imh_pkg::ID_BITS-1:0]   in_entry_id,
  input  logic [imh_pkg::KEY_IN_BITS-1:0] in_key,
  input  logic                          clearing,
  output imh_pkg::head_t                head,
  input  logic                          head_pop
);
  import imh_pkg::*;

  item_t       fifo_r [2];
  logic        wr_ptr_r, wr_ptr_nxt;
  logic        rd_ptr_r, rd_ptr_nxt;
  logic [1:0]  fill_r, fill_nxt;
  logic        push_ok, pop_ok;
  op_t         op_dec;
  item_t       item_in;

  always_comb begin
    unique case (in_mode)
      3'd0:    op_dec = OP_APPEND;
      3'd1:    op_dec = OP_BUILD;
      3'd2:    op_dec = OP_CHANGE;
      3'd3:    op_dec = OP_REMOVE;
      3'd4:    op_dec = OP_LOCATE;
      default: op_dec = OP_NONE;
    endcase
  end

  assign item_in    = '{op: op_dec, position: in_position, entry_id: in_entry_id, key: in_key};
  assign in_full    = (fill_r == 2'd2) || clearing;
  assign push_ok    = in_push && !in_full;
  assign head.valid = (fill_r != 2'd0);
  assign head.item  = fifo_r[rd_ptr_r];
  assign pop_ok     = head_pop && head.valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push_ok;
    rd_ptr_nxt = rd_ptr_r ^ pop_ok;
    fill_nxt   = fill_r + 2'(push_ok) - 2'(pop_ok);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      fifo_r[wr_ptr_r] <= item_in;
    end
  end

endmodule

>>> hw/rtl/imh_back.sv
`timescale 1ns / 1ps

module imh_back #(
  parameter int CAPACITY = imh_pkg::CAPACITY_DEF,
  parameter int KEY_BITS = imh_pkg::KEY_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  imh_pkg::head_t                  head,
  output logic                            head_pop,
  output logic                            clearing,
  output logic                            out_empty,
  input  logic                            out_pop,
  output logic [1:0]                      out_status,
  output logic [imh_pkg::FPOS_BITS-1:0]   out_final_position,
  output logic [imh_pkg::KEY_IN_BITS-1:0] out_min_key,
  output logic [imh_pkg::ID_BITS-1:0]     out_min_id,
  output logic [imh_pkg::FPOS_BITS-1:0]   out_count,
  output logic                            out_empty_res
);
  import imh_pkg::*;

  localparam int PW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = PW + 2;
  localparam int BW = CW + POS_BITS;
  localparam int EW = KEY_BITS + ID_BITS;

  typedef enum logic [7:0] {
    S_CLR  = 8'b0000_0001,
    S_IDLE = 8'b0000_0010,
    S_LD   = 8'b0000_0100,
    S_LDQ  = 8'b0000_1000,
    S_SRD  = 8'b0001_0000,
    S_SCMP = 8'b0010_0000,
    S_ROOT = 8'b0100_0000,
    S_DONE = 8'b1000_0000
  } state_t;

  logic [EW-1:0]        slot_mem [CAPACITY];
  logic [FPOS_BITS-1:0] map_mem  [ID_SPACE];
  logic                 hit_mem  [ID_SPACE];

  logic [EW-1:0]        q0_r, q1_r;
  logic [FPOS_BITS-1:0] map_q_r;
  logic                 hit_q_r;

  logic [PW-1:0]        a0, a1;
  logic                 slot_we;
  logic [PW-1:0]        slot_wa;
  logic [EW-1:0]        slot_wd;
  logic                 map_we;
  logic [ID_BITS-1:0]   map_wa;
  logic [FPOS_BITS-1:0] map_wd;
  logic                 hit_we;
  logic [ID_BITS-1:0]   hit_wa;
  logic                 hit_wd;

  state_t               state_r, state_nxt;
  logic [CW-1:0]        count_r, count_nxt;
  logic [ID_BITS-1:0]   clr_r, clr_nxt;
  logic                 out_valid_r, out_valid_nxt;

  op_t                  op_r, op_nxt;
  logic [PW-1:0]        pos_r, pos_nxt;
  logic [ID_BITS-1:0]   id_r, id_nxt;
  logic [KEY_BITS-1:0]  key_r, key_nxt;
  logic [PW-1:0]        i_r, i_nxt;
  logic [PW-1:0]        bi_r, bi_nxt;
  logic [KEY_BITS-1:0]  ek_r, ek_nxt;
  logic [ID_BITS-1:0]   eid_r, eid_nxt;
  logic                 down_r, down_nxt;
  logic                 build_r, build_nxt;
  logic [FPOS_BITS-1:0] fpos_r, fpos_nxt;
  status_t              status_r, status_nxt;

  logic [1:0]           o_status_r, o_status_nxt;
  logic [FPOS_BITS-1:0] o_fpos_r, o_fpos_nxt;
  logic [KEY_IN_BITS-1:0] o_key_r, o_key_nxt;
  logic [ID_BITS-1:0]   o_id_r, o_id_nxt;
  logic [FPOS_BITS-1:0] o_count_r, o_count_nxt;
  logic                 o_er_r, o_er_nxt;

  logic [KEY_BITS-1:0]  q0k, q1k;
  logic [ID_BITS-1:0]   q0id, q1id;
  logic [XW-1:0]        c_x, c1_x, cnt_x;
  logic [PW-1:0]        c_pa, c1_pa, i_m1, parent, last;
  logic                 use_r, fin, out_free, is_full, bad_pos;
  logic [EW-1:0]        ch;
  logic [PW-1:0]        ci;
  logic [CW-1:0]        half;

  assign q0k   = q0_r[KEY_BITS-1:0];
  assign q1k   = q1_r[KEY_BITS-1:0];
  assign q0id  = q0_r[EW-1 -: ID_BITS];
  assign q1id  = q1_r[EW-1 -: ID_BITS];
  assign c_x   = XW'({i_r, 1'b1});
  assign c1_x  = c_x + XW'(1);
  assign cnt_x = XW'(count_r);
  assign c_pa  = PW'(c_x);
  assign c1_pa = PW'(c1_x);
  assign i_m1  = i_r - PW'(1);
  assign parent = i_m1 >> 1;
  assign last  = PW'(count_r - CW'(1));
  assign half  = count_r >> 1;
  assign is_full = (count_r == CW'(CAPACITY));
  assign bad_pos = BW'(head.item.position) >= BW'(count_r);
  assign out_free = !out_valid_r || out_pop;
  assign use_r = (c1_x < cnt_x) && (q0k > q1k);
  assign ch    = use_r ? q1_r : q0_r;
  assign ci    = use_r ? c1_pa : c_pa;
  assign clearing = (state_r == S_CLR);

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    clr_nxt = clr_r;
    out_valid_nxt = out_valid_r && !out_pop;
    op_nxt = op_r;
    pos_nxt = pos_r;
    id_nxt = id_r;
    key_nxt = key_r;
    i_nxt = i_r;
    bi_nxt = bi_r;
    ek_nxt = ek_r;
    eid_nxt = eid_r;
    down_nxt = down_r;
    build_nxt = build_r;
    fpos_nxt = fpos_r;
    status_nxt = status_r;
    o_status_nxt = o_status_r;
    o_fpos_nxt = o_fpos_r;
    o_key_nxt = o_key_r;
    o_id_nxt = o_id_r;
    o_count_nxt = o_count_r;
    o_er_nxt = o_er_r;
    a0 = '0;
    a1 = '0;
    slot_we = 1'b0;
    slot_wa = i_r;
    slot_wd = {eid_r, ek_r};
    map_we = 1'b0;
    map_wa = eid_r;
    map_wd = FPOS_BITS'(i_r);
    hit_we = 1'b0;
    hit_wa = id_r;
    hit_wd = 1'b0;
    head_pop = 1'b0;
    fin = 1'b0;

    unique case (state_r)
      S_CLR: begin
        hit_we = 1'b1;
        hit_wa = clr_r;
        hit_wd = 1'b0;
        clr_nxt = clr_r + ID_BITS'(1);
        if (clr_r == ID_BITS'(ID_SPACE - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (head.valid) begin
          head_pop = 1'b1;
          op_nxt = head.item.op;
          pos_nxt = PW'(head.item.position);
          id_nxt = head.item.entry_id;
          key_nxt = KEY_BITS'(head.item.key);
          status_nxt = ST_OK;
          fpos_nxt = POS_ABSENT;
          build_nxt = 1'b0;
          state_nxt = S_ROOT;
          case (head.item.op) inside
            OP_APPEND: begin
              if (is_full) begin
                status_nxt = ST_FULL;
              end else begin
                slot_we = 1'b1;
                slot_wa = PW'(count_r);
                slot_wd = {head.item.entry_id, KEY_BITS'(head.item.key)};
                map_we = 1'b1;
                map_wa = head.item.entry_id;
                map_wd = FPOS_BITS'(count_r);
                hit_we = 1'b1;
                hit_wa = head.item.entry_id;
                hit_wd = 1'b1;
                fpos_nxt = FPOS_BITS'(count_r);
                count_nxt = count_r + CW'(1);
              end
            end
            OP_BUILD: begin
              fpos_nxt = '0;
              if (half != '0) begin
                build_nxt = 1'b1;
                bi_nxt = PW'(half - CW'(1));
                state_nxt = S_LD;
              end
            end
            OP_CHANGE, OP_REMOVE: begin
              if (bad_pos) begin
                status_nxt = ST_BAD_POS;
              end else begin
                state_nxt = S_LD;
              end
            end
            OP_LOCATE: state_nxt = S_LD;
            default: state_nxt = S_ROOT;
          endcase
        end
      end
      S_LD: begin
        a0 = build_r ? bi_r : pos_r;
        a1 = last;
        state_nxt = S_LDQ;
      end
      S_LDQ: begin
        state_nxt = S_SRD;
        case (op_r)
          OP_BUILD: begin
            ek_nxt = q0k;
            eid_nxt = q0id;
            i_nxt = bi_r;
            down_nxt = 1'b1;
          end
          OP_CHANGE: begin
            ek_nxt = key_r;
            eid_nxt = q0id;
            i_nxt = pos_r;
            down_nxt = q0k < key_r;
          end
          OP_REMOVE: begin
            hit_we = 1'b1;
            hit_wa = q0id;
            hit_wd = 1'b0;
            count_nxt = count_r - CW'(1);
            ek_nxt = q1k;
            eid_nxt = q1id;
            i_nxt = pos_r;
            down_nxt = q0k < q1k;
            if (pos_r == last) begin
              state_nxt = S_ROOT;
            end
          end
          default: begin
            fpos_nxt = hit_q_r ? map_q_r : POS_ABSENT;
            state_nxt = S_ROOT;
          end
        endcase
      end
      S_SRD: begin
        if (down_r) begin
          if (c_x >= cnt_x) begin
            fin = 1'b1;
          end else begin
            a0 = c_pa;
            a1 = c1_pa;
            state_nxt = S_SCMP;
          end
        end else begin
          if (i_r == '0) begin
            fin = 1'b1;
          end else begin
            a0 = parent;
            state_nxt = S_SCMP;
          end
        end
      end
      S_SCMP: begin
        if (down_r) begin
          if (ek_r > ch[KEY_BITS-1:0]) begin
            slot_we = 1'b1;
            slot_wd = ch;
            map_we = 1'b1;
            map_wa = ch[EW-1 -: ID_BITS];
            i_nxt = ci;
            state_nxt = S_SRD;
          end else begin
            fin = 1'b1;
          end
        end else begin
          if (q0k > ek_r) begin
            slot_we = 1'b1;
            slot_wd = q0_r;
            map_we = 1'b1;
            map_wa = q0id;
            i_nxt = parent;
            state_nxt = S_SRD;
          end else begin
            fin = 1'b1;
          end
        end
      end
      S_ROOT: begin
        a0 = '0;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          o_status_nxt = status_r;
          o_fpos_nxt = fpos_r;
          o_key_nxt = (count_r != '0) ? KEY_IN_BITS'(q0k) : '0;
          o_id_nxt = (count_r != '0) ? q0id : '0;
          o_count_nxt = FPOS_BITS'(count_r);
          o_er_nxt = (count_r == '0);
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (fin) begin
      slot_we = 1'b1;
      slot_wa = i_r;
      slot_wd = {eid_r, ek_r};
      map_we = (op_r == OP_REMOVE) || (i_r != (build_r ? bi_r : pos_r));
      map_wa = eid_r;
      map_wd = FPOS_BITS'(i_r);
      if (build_r && (bi_r != '0)) begin
        bi_nxt = bi_r - PW'(1);
        state_nxt = S_LD;
      end else begin
        if (op_r == OP_CHANGE) begin
          fpos_nxt = FPOS_BITS'(i_r);
        end
        state_nxt = S_ROOT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (slot_we) begin
      slot_mem[slot_wa] <= slot_wd;
    end
    q0_r <= slot_mem[a0];
    q1_r <= slot_mem[a1];
  end

  always_ff @(posedge clk) begin
    if (map_we) begin
      map_mem[map_wa] <= map_wd;
    end
    map_q_r <= map_mem[id_r];
  end

  always_ff @(posedge clk) begin
    if (hit_we) begin
      hit_mem[hit_wa] <= hit_wd;
    end
    hit_q_r <= hit_mem[id_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      count_r     <= '0;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      build_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
      build_r     <= build_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    pos_r      <= pos_nxt;
    id_r       <= id_nxt;
    key_r      <= key_nxt;
    i_r        <= i_nxt;
    bi_r       <= bi_nxt;
    ek_r       <= ek_nxt;
    eid_r      <= eid_nxt;
    down_r     <= down_nxt;
    fpos_r     <= fpos_nxt;
    status_r   <= status_nxt;
    o_status_r <= o_status_nxt;
    o_fpos_r   <= o_fpos_nxt;
    o_key_r    <= o_key_nxt;
    o_id_r     <= o_id_nxt;
    o_count_r  <= o_count_nxt;
    o_er_r     <= o_er_nxt;
  end

  assign out_empty          = !out_valid_r;
  assign out_status         = o_status_r;
  assign out_final_position = o_fpos_r;
  assign out_min_key        = o_key_r;
  assign out_min_id         = o_id_r;
  assign out_count          = o_count_r;
  assign out_empty_res      = o_er_r;

endmodule
